@@ hdl/urld_pkg.sv @@
// Shared types and constants for the USB receive length-header deframer.
`timescale 1ns / 1ps

package urld_pkg;

    // Defaults for the top-level parameters and configuration register
    localparam int LEN_BITS_DEFAULT      = 11;
    localparam int MAX_ACCEPT_LEN_RESET  = 1514;

    // Header layout: length in the low bits, its complement from bit 16 up
    localparam int CPL_SHIFT             = 16;
    localparam int HDR_LOW_BITS          = 24;
    localparam logic [1:0] HDR_LAST_IDX  = 2'd3;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PAD     = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MALFORMED  = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_TRUNCATED  = 3'd3,
        ST_TOOLONG    = 3'd4
    } status_t;

endpackage

@@ hdl/usb_rx_length_header_deframer.sv @@
// Length-header deframer: parses 4-byte headers and forwards packet payload bytes.
`timescale 1ns / 1ps

// Usage
//   s_axis carries the received byte stream, one byte per item; s_axis_tlast
//   marks the last byte currently available (end of burst). Each packet opens
//   with a 4-byte little-endian header whose low LEN_BITS bits give the length
//   and whose bits from 16 up hold its complement. Payload bytes come out on
//   m_axis with tuser[0] set; the item that ends a packet or reports an error
//   carries tlast, a status in tuser[3:1] and the header length in tdata.
//   Odd-length packets are followed by one pad byte, which is skipped.
//   Packets longer than max_accept_len (cfg_we / cfg_wdata) are consumed and
//   reported with a too-long status only, or a truncated one if the burst ends first.
//   The result item of an accepted byte is registered and is shown in the
//   next cycle. One byte per cycle is accepted while m_axis is not stalled;
//   the single output register takes a new result in the same cycle the old one leaves.
//   Reset clears the parser to the header phase and loads max_accept_len with
//   1514. When the receiver stalls, the output register holds its item and
//   s_axis_tready drops only while that register is full and not drained.
module usb_rx_length_header_deframer #(
    parameter int LEN_BITS = urld_pkg::LEN_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration: max_accept_len
    input  logic                    cfg_we,
    input  logic [LEN_BITS-1:0]     cfg_wdata,
    // Received byte stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] rx_byte
    input  logic                    s_axis_tlast,   // burst_end
    // Result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [((8+LEN_BITS+7)/8)*8-1:0] m_axis_tdata,
                                    // [7:0] payload_byte, [8+LEN_BITS-1:8] frame_length
    output logic                    m_axis_tlast,   // frame_end
    output logic [3:0]              m_axis_tuser    // [0] data_valid, [3:1] frame_status
);

    localparam int TDATA_W = ((8 + LEN_BITS + 7) / 8) * 8;

    // Parser state
    urld_pkg::phase_t                  phase_reg, phase_next;
    logic [urld_pkg::HDR_LOW_BITS-1:0] hdr_reg, hdr_next;
    logic [LEN_BITS-1:0]               idx_reg, idx_next;
    logic [LEN_BITS-1:0]               pkt_len_reg, pkt_len_next;
    logic                              drop_reg, drop_next;
    logic [LEN_BITS-1:0]               max_len_reg;

    // Output register
    logic                              out_valid_reg;
    logic                              out_dv_reg;
    logic [7:0]                        out_byte_reg;
    logic                              out_end_reg;
    urld_pkg::status_t                 out_status_reg;
    logic [LEN_BITS-1:0]               out_len_reg;

    // Result of the current item
    logic                              res_valid;
    logic                              res_dv;
    logic [7:0]                        res_byte;
    logic                              res_end;
    urld_pkg::status_t                 res_status;
    logic [LEN_BITS-1:0]               res_len;

    // Decode helpers
    logic                              accept;
    logic [7:0]                        in_byte;
    logic                              in_last;
    logic [31:0]                       hdr_word;
    logic [LEN_BITS-1:0]               hdr_len;
    logic [LEN_BITS-1:0]               hdr_cpl;
    logic                              hdr_done;
    logic                              hdr_bad;
    logic                              hdr_zero;
    logic [LEN_BITS:0]                 idx_inc;
    logic                              pay_end;

    assign in_byte  = s_axis_tdata;
    assign in_last  = s_axis_tlast;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Header word and length check
    assign hdr_word = {in_byte, hdr_reg};
    assign hdr_len  = hdr_word[LEN_BITS-1:0];
    assign hdr_cpl  = ~hdr_word[urld_pkg::CPL_SHIFT +: LEN_BITS];
    assign hdr_done = (idx_reg[1:0] == urld_pkg::HDR_LAST_IDX);
    assign hdr_bad  = (hdr_cpl != hdr_len);
    assign hdr_zero = (hdr_len == '0);

    // Payload position
    assign idx_inc  = {1'b0, idx_reg} + (LEN_BITS+1)'(1);
    assign pay_end  = (idx_inc >= {1'b0, pkt_len_reg});

    // Next parser state
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_next     = hdr_reg;
        idx_next     = idx_reg;
        pkt_len_next = pkt_len_reg;
        drop_next    = drop_reg;
        unique case (phase_reg)
            urld_pkg::PH_HEADER:
            begin
                if (!hdr_done)
                begin
                    unique case (idx_reg[1:0])
                        2'd0:    hdr_next[7:0]   = in_byte;
                        2'd1:    hdr_next[15:8]  = in_byte;
                        default: hdr_next[23:16] = in_byte;
                    endcase
                    idx_next = idx_reg + LEN_BITS'(1);
                    if (in_last)
                    begin
                        hdr_next = '0;
                        idx_next = '0;
                    end
                end
                else
                begin
                    hdr_next = '0;
                    idx_next = '0;
                    priority if (hdr_bad)
                        phase_next = in_last ? urld_pkg::PH_HEADER : urld_pkg::PH_DISCARD;
                    else if (hdr_zero || in_last)
                        phase_next = urld_pkg::PH_HEADER;
                    else
                    begin
                        pkt_len_next = hdr_len;
                        drop_next    = (hdr_len > max_len_reg);
                        phase_next   = urld_pkg::PH_PAYLOAD;
                    end
                end
            end
            urld_pkg::PH_PAYLOAD:
            begin
                priority if (pay_end)
                begin
                    idx_next   = '0;
                    drop_next  = 1'b0;
                    phase_next = (pkt_len_reg[0] && !in_last) ? urld_pkg::PH_PAD
                                                              : urld_pkg::PH_HEADER;
                end
                else if (in_last)
                begin
                    idx_next   = '0;
                    drop_next  = 1'b0;
                    phase_next = urld_pkg::PH_HEADER;
                end
                else
                begin
                    idx_next = idx_inc[LEN_BITS-1:0];
                end
            end
            urld_pkg::PH_PAD:
            begin
                phase_next = urld_pkg::PH_HEADER;
            end
            default:
            begin
                if (in_last)
                    phase_next = urld_pkg::PH_HEADER;
            end
        endcase
    end

    // Result of the current item
    always_comb
    begin
        res_valid  = 1'b0;
        res_dv     = 1'b0;
        res_byte   = '0;
        res_end    = 1'b0;
        res_status = urld_pkg::ST_OK;
        res_len    = '0;
        unique case (phase_reg)
            urld_pkg::PH_HEADER:
            begin
                if (!hdr_done)
                begin
                    if (in_last)
                    begin
                        res_valid  = 1'b1;
                        res_end    = 1'b1;
                        res_status = urld_pkg::ST_INCOMPLETE;
                    end
                end
                else
                begin
                    priority if (hdr_bad)
                    begin
                        res_valid  = 1'b1;
                        res_end    = 1'b1;
                        res_status = urld_pkg::ST_MALFORMED;
                        res_len    = hdr_len;
                    end
                    else if (hdr_zero)
                    begin
                        res_valid  = 1'b1;
                        res_end    = 1'b1;
                    end
                    else if (in_last)
                    begin
                        res_valid  = 1'b1;
                        res_end    = 1'b1;
                        res_status = urld_pkg::ST_TRUNCATED;
                        res_len    = hdr_len;
                    end
                    else
                    begin
                        // Good header: the payload follows, no result yet
                        res_valid  = 1'b0;
                    end
                end
            end
            urld_pkg::PH_PAYLOAD:
            begin
                priority if (pay_end)
                begin
                    res_valid = 1'b1;
                    res_end   = 1'b1;
                    res_len   = pkt_len_reg;
                    if (drop_reg)
                        res_status = urld_pkg::ST_TOOLONG;
                    else
                    begin
                        res_dv   = 1'b1;
                        res_byte = in_byte;
                    end
                end
                else if (in_last)
                begin
                    res_valid  = 1'b1;
                    res_end    = 1'b1;
                    res_status = urld_pkg::ST_TRUNCATED;
                    res_len    = pkt_len_reg;
                end
                else if (!drop_reg)
                begin
                    res_valid = 1'b1;
                    res_dv    = 1'b1;
                    res_byte  = in_byte;
                end
                else
                begin
                    // Swallow the bytes of a too-long packet
                    res_valid = 1'b0;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= urld_pkg::PH_HEADER;
            hdr_reg     <= '0;
            idx_reg     <= '0;
            pkt_len_reg <= '0;
            drop_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            hdr_reg     <= hdr_next;
            idx_reg     <= idx_next;
            pkt_len_reg <= pkt_len_next;
            drop_reg    <= drop_next;
        end
    end

    // Hold the acceptance limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= LEN_BITS'(urld_pkg::MAX_ACCEPT_LEN_RESET);
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    // Load a new result or drain the held one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_dv_reg     <= res_dv;
            out_byte_reg   <= res_byte;
            out_end_reg    <= res_end;
            out_status_reg <= res_status;
            out_len_reg    <= res_len;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({out_len_reg, out_byte_reg});
    assign m_axis_tlast  = out_end_reg;
    assign m_axis_tuser  = {out_status_reg, out_dv_reg};

    // A delivered byte never carries an error status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == urld_pkg::ST_OK)
        else $error("data byte delivered with error status");

    // A mid-packet byte carries no status and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[3:1] == urld_pkg::ST_OK
            && out_len_reg == '0 && m_axis_tuser[0])
        else $error("non-final result without data");

    // The payload counter stays below the packet length
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == urld_pkg::PH_PAYLOAD |-> idx_reg < pkt_len_reg && pkt_len_reg != '0)
        else $error("payload index out of range");

    // The header counter stays within the four header bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != urld_pkg::PH_PAYLOAD |-> idx_reg <= LEN_BITS'(3))
        else $error("header index out of range");

    // The end of a burst always returns the parser to the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> phase_reg == urld_pkg::PH_HEADER && idx_reg == '0)
        else $error("parser not reset at burst end");

endmodule
